// ===== hdl/imr_pkg.sv =====
// Shared types, sizes and the compare helper for the interval merge block.
`default_nettype none

package imr_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 16;

  // Sweep states
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
  } span_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic  valid;
    logic  lt;     // incoming key sorts ahead of this cell's contents, or the cell is empty
    span_t span;
  } link_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic  ins;
    logic  pop;
    span_t key;
  } cell_ctl_t;

  localparam link_t NO_LINK = '{valid: 1'b0, lt: 1'b0, span: '0};

  // Order by start, then by end, both signed ascending
  function automatic logic span_before(input span_t a, input span_t b);
    logic lo_lt;
    logic lo_eq;
    logic hi_lt;
    lo_lt = $signed(a.lo) < $signed(b.lo);
    lo_eq = a.lo == b.lo;
    hi_lt = $signed(a.hi) < $signed(b.hi);
    return lo_lt || (lo_eq && hi_lt);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/imr_if.sv =====
// Request channel interfaces: interval input and merged result output.
`default_nettype none

interface imr_in_if
  import imr_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] interval_start;
  logic signed [VALUE_WIDTH-1:0] interval_end;
  logic                          last_interval;

  modport source (output valid, output interval_start, output interval_end,
                  output last_interval, input ready);
  modport sink   (input valid, input interval_start, input interval_end,
                  input last_interval, output ready);
endinterface

interface imr_out_if
  import imr_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] merged_start;
  logic signed [VALUE_WIDTH-1:0] merged_end;
  logic                          final_result;
  logic                          overflow_flag;

  modport source (output valid, output merged_start, output merged_end,
                  output final_result, output overflow_flag, input ready);
  modport sink   (input valid, input merged_start, input merged_end,
                  input final_result, input overflow_flag, output ready);
endinterface

`default_nettype wire

// ===== hdl/imr_cell.sv =====
// One cell of the sorting row: holds one interval, inserts or shifts.
`default_nettype none

module imr_cell
  import imr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire link_t     prev_link,
  input  wire link_t     next_link,
  output link_t          link
);

  span_t span_r, span_nxt;
  logic  valid_r, valid_nxt;
  logic  lt;

  assign lt = !valid_r || span_before(ctl.key, span_r);

  always_comb begin
    span_nxt  = span_r;
    valid_nxt = valid_r;
    priority if (ctl.pop) begin
      span_nxt  = next_link.span;
      valid_nxt = next_link.valid;
    end else if (ctl.ins) begin
      // row stays sorted: the cell where the key lands and all after it move down
      if (prev_link.lt) begin
        span_nxt  = prev_link.span;
        valid_nxt = prev_link.valid;
      end else if (lt) begin
        span_nxt  = ctl.key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  assign link.valid = valid_r;
  assign link.lt    = lt;
  assign link.span  = span_r;

endmodule

`default_nettype wire

// ===== hdl/imr_sweep.sv =====
// Sweep unit: pops sorted intervals from the row head, merges, emits results.
`default_nettype none

module imr_sweep
  import imr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_acc,
  input  wire logic   in_last,
  input  wire logic   full,
  input  wire link_t  head,
  output logic        load_phase,
  output logic        pop,
  imr_out_if.source   out_ch
);

  logic  state_r, state_nxt;
  logic  dropped_r, dropped_nxt;
  logic  ovf_r, ovf_nxt;
  logic  have_cur_r, have_cur_nxt;
  span_t cur_r, cur_nxt;
  logic  out_valid_r, out_valid_nxt;
  span_t out_span_r, out_span_nxt;
  logic  out_final_r, out_final_nxt;
  logic  out_ovf_r, out_ovf_nxt;

  logic slot_free;
  logic step;
  logic head_joins;
  logic emit;
  logic emit_final;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign step       = (state_r == ST_SWEEP) && slot_free;
  assign head_joins = $signed(head.span.lo) <= $signed(cur_r.hi);
  assign load_phase = state_r == ST_LOAD;

  always_comb begin
    state_nxt    = state_r;
    dropped_nxt  = dropped_r;
    ovf_nxt      = ovf_r;
    have_cur_nxt = have_cur_r;
    cur_nxt      = cur_r;
    pop          = 1'b0;
    emit         = 1'b0;
    emit_final   = 1'b0;
    if (step) begin
      if (head.valid) begin
        pop = 1'b1;
        if (!have_cur_r) begin
          cur_nxt      = head.span;
          have_cur_nxt = 1'b1;
        end else if (head_joins) begin
          if ($signed(head.span.hi) > $signed(cur_r.hi)) begin
            cur_nxt.hi = head.span.hi;
          end
        end else begin
          emit    = 1'b1;
          cur_nxt = head.span;
        end
      end else begin
        // row drained: close the open merged interval
        emit         = 1'b1;
        emit_final   = 1'b1;
        have_cur_nxt = 1'b0;
        state_nxt    = ST_LOAD;
      end
    end else if ((state_r == ST_LOAD) && in_acc) begin
      dropped_nxt = dropped_r | full;
      if (in_last) begin
        state_nxt   = ST_SWEEP;
        ovf_nxt     = dropped_r | full;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_span_nxt  = out_span_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_span_nxt  = cur_r;
      out_final_nxt = emit_final;
      out_ovf_nxt   = ovf_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      dropped_r   <= 1'b0;
      have_cur_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      have_cur_r  <= have_cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r       <= ovf_nxt;
    cur_r       <= cur_nxt;
    out_span_r  <= out_span_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.merged_start  = $signed(out_span_r.lo);
  assign out_ch.merged_end    = $signed(out_span_r.hi);
  assign out_ch.final_result  = out_final_r;
  assign out_ch.overflow_flag = out_ovf_r;

`ifndef SYNTH
  a_close_has_open: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !head.valid) |-> have_cur_r)
    else $error("closing a set with no open merged interval");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && head.valid && have_cur_r)
      |-> ($signed(head.span.lo) >= $signed(cur_r.lo)))
    else $error("row head sorts ahead of the open merged interval");

  a_final_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_final) |=> ((state_r == ST_LOAD) && !have_cur_r))
    else $error("sweep did not return to load after the final result");
`endif

endmodule

`default_nettype wire

// ===== hdl/interval_merge.sv =====
// Interval merge top level: sorting cell row plus sweep unit.
//
// Intervals enter one per cycle into a row of CAPACITY cells that keeps
// them sorted by start, then end, as they arrive. The item marked last
// starts the sweep: the row shifts one interval per cycle into the merge
// unit while the result side is not stalling, and no input is taken during
// that sweep. Results are registered; loading of the next set begins while
// the final result still waits. Intervals past CAPACITY are dropped and
// every result of that set carries overflow_flag.
`default_nettype none

module interval_merge
  import imr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  imr_in_if.sink    in_ch,
  imr_out_if.source out_ch
);

  link_t             cell_link [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  cell_ctl_t         ctl;
  logic              in_acc;
  logic              full;
  logic              load_phase;
  logic              pop;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign full     = cell_valid[CAPACITY-1];
  assign in_ch.ready = load_phase;

  assign ctl.ins    = in_acc && !full;
  assign ctl.pop    = pop;
  assign ctl.key.lo = in_ch.interval_start;
  assign ctl.key.hi = in_ch.interval_end;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev_link;
    link_t next_link;

    if (i == 0) begin : g_first
      assign prev_link = NO_LINK;
    end else begin : g_mid
      assign prev_link = cell_link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_link = NO_LINK;
    end else begin : g_inner
      assign next_link = cell_link[i+1];
    end

    imr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_link (prev_link),
      .next_link (next_link),
      .link      (cell_link[i])
    );

    assign cell_valid[i] = cell_link[i].valid;
  end

  imr_sweep u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_last    (in_ch.last_interval),
    .full       (full),
    .head       (cell_link[0]),
    .load_phase (load_phase),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("occupied cells are not a contiguous run from the head");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_link[1].valid |-> !span_before(cell_link[1].span, cell_link[0].span))
    else $error("row head is not the smallest interval");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/imr_merge_checker.sv =====
// Watches both channels, predicts merged intervals and compares results.
`timescale 1ns / 1ps

module imr_merge_checker
  import imr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  imr_in_if         in_mon,
  imr_out_if        out_mon,
  output int        fail_count,
  output int        pending_results
);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct {
    value_t lo;
    value_t hi;
  } range_t;

  typedef struct {
    value_t start_v;
    value_t end_v;
    logic   last_one;
    logic   ovf;
  } merged_t;

  range_t  held[CAPACITY];
  int      held_count;
  bit      dropped;
  merged_t merged_q[$];
  int      mismatches = 0;
  int      outstanding = 0;

  assign fail_count      = mismatches;
  assign pending_results = outstanding;

  function automatic bit sorts_ahead(range_t a, range_t b);
    if (a.lo != b.lo) return a.lo < b.lo;
    return a.hi < b.hi;
  endfunction

  function automatic void queue_merged(value_t lo, value_t hi, logic last_one);
    merged_t m;
    m.start_v  = lo;
    m.end_v    = hi;
    m.last_one = last_one;
    m.ovf      = dropped;
    merged_q   = {merged_q, m};
  endfunction

  // Order the held set, sweep it and queue the merged intervals
  function automatic void merge_held();
    range_t key;
    range_t run;
    int     j;
    for (int i = 1; i < held_count; i++) begin
      key = held[i];
      j   = i;
      while (j > 0 && sorts_ahead(key, held[j-1])) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = key;
    end
    run = held[0];
    for (int i = 1; i < held_count; i++) begin
      if (held[i].lo <= run.hi) begin
        if (held[i].hi > run.hi) run.hi = held[i].hi;
      end else begin
        queue_merged(run.lo, run.hi, 1'b0);
        run = held[i];
      end
    end
    queue_merged(run.lo, run.hi, 1'b1);
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void take_interval();
    if (held_count < CAPACITY) begin
      held[held_count] = '{in_mon.interval_start, in_mon.interval_end};
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (in_mon.last_interval) merge_held();
  endfunction

  function automatic void check_merged();
    merged_t want;
    if (merged_q.size() == 0) begin
      $error("unexpected result: start %0d end %0d", out_mon.merged_start,
             out_mon.merged_end);
      mismatches++;
      return;
    end
    want = merged_q.pop_front();
    if (out_mon.merged_start !== want.start_v) begin
      $error("merged_start: expected %0d, got %0d", want.start_v, out_mon.merged_start);
      mismatches++;
    end
    if (out_mon.merged_end !== want.end_v) begin
      $error("merged_end: expected %0d, got %0d", want.end_v, out_mon.merged_end);
      mismatches++;
    end
    if (out_mon.final_result !== want.last_one) begin
      $error("final_result: expected %0b, got %0b", want.last_one, out_mon.final_result);
      mismatches++;
    end
    if (out_mon.overflow_flag !== want.ovf) begin
      $error("overflow_flag: expected %0b, got %0b", want.ovf, out_mon.overflow_flag);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      dropped    = 1'b0;
    end else begin
      // results are registered, so one accepted here never stems from this edge's request
      if (out_mon.valid && out_mon.ready) check_merged();
      if (in_mon.valid && in_mon.ready) take_interval();
    end
    outstanding <= merged_q.size();
  end

endmodule

// ===== tb/sv/tb_interval_merge.sv =====
// Top of the interval merge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_interval_merge;
  import imr_pkg::*;

  localparam int VAL_MIN = -(1 <<< (VALUE_WIDTH - 1));
  localparam int VAL_MAX = (1 <<< (VALUE_WIDTH - 1)) - 1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   sent_total;

  imr_in_if  in_ch ();
  imr_out_if out_ch ();

  interval_merge uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  imr_merge_checker watcher (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [VALUE_WIDTH-1:0] fit(int v);
    if (v < VAL_MIN) return VALUE_WIDTH'(VAL_MIN);
    if (v > VAL_MAX) return VALUE_WIDTH'(VAL_MAX);
    return VALUE_WIDTH'(v);
  endfunction

  function automatic int any_value();
    logic signed [VALUE_WIDTH-1:0] r;
    r = VALUE_WIDTH'($urandom);
    return int'(r);
  endfunction

  // One request per interval; valid stays high across back-to-back requests
  task automatic send_interval(int s, int e, bit last_one, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.interval_start <= fit(s);
    in_ch.interval_end   <= fit(e);
    in_ch.last_interval  <= last_one;
    do @(posedge clk); while (!in_ch.ready);
    sent_total++;
  endtask

  // Clustered sets give real overlaps; wide ones spread over the full range
  task automatic send_random_set(int forced_size);
    int size;
    int sel;
    bit wide;
    int base;
    int spread;
    int s;
    int e;
    bit calm;
    sel = $urandom_range(0, 19);
    if (forced_size > 0) size = forced_size;
    else if (sel < 15) size = $urandom_range(1, 10);
    else if (sel < 17) size = $urandom_range(28, 32);
    else size = $urandom_range(33, 40);
    wide   = ($urandom_range(0, 3) == 0);
    calm   = ($urandom_range(0, 4) == 0);
    base   = any_value();
    spread = $urandom_range(4, 400);
    for (int k = 0; k < size; k++) begin
      if (wide) begin
        s = any_value();
        e = ($urandom_range(0, 7) == 0) ? any_value() : s + $urandom_range(0, VAL_MAX);
      end else begin
        s = base + $urandom_range(0, spread);
        if ($urandom_range(0, 9) == 0) e = s - $urandom_range(1, 50);
        else e = s + $urandom_range(0, spread / 4 + 1);
      end
      send_interval(s, e, k == size - 1, calm);
    end
  endtask

  // Result side: random stalls, with calm stretches now and then
  initial begin
    int  stall;
    bit  calm;
    out_ch.ready <= 1'b0;
    calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    sent_total = 0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.interval_start <= '0;
    in_ch.interval_end   <= '0;
    in_ch.last_interval  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full range as one interval
    send_interval(VAL_MIN, VAL_MAX, 1'b1, 1'b0);
    // extremes arriving out of order
    send_interval(VAL_MAX, VAL_MAX, 1'b0, 1'b1);
    send_interval(VAL_MIN, VAL_MIN, 1'b1, 1'b1);
    // touching intervals merge, a gap of one does not
    send_interval(0, 5, 1'b0, 1'b0);
    send_interval(5, 9, 1'b0, 1'b0);
    send_interval(10, 12, 1'b1, 1'b0);
    // equal starts and nesting
    send_interval(3, 20, 1'b0, 1'b1);
    send_interval(3, 4, 1'b0, 1'b1);
    send_interval(1, 2, 1'b0, 1'b1);
    send_interval(3, 10, 1'b1, 1'b1);
    // ends below starts, standalone and inside a larger interval
    send_interval(10, 5, 1'b0, 1'b0);
    send_interval(7, 8, 1'b0, 1'b0);
    send_interval(20, 15, 1'b0, 1'b0);
    send_interval(-40, -30, 1'b0, 1'b0);
    send_interval(-35, -60, 1'b0, 1'b0);
    send_interval(30, 29, 1'b1, 1'b0);
    // negatives
    send_interval(-5, -1, 1'b0, 1'b0);
    send_interval(-1, 3, 1'b0, 1'b0);
    send_interval(-100, -50, 1'b1, 1'b0);

    // store filled exactly, then one past capacity with the last item dropped
    send_random_set(CAPACITY);
    send_random_set(CAPACITY + 1);
    while (sent_total < 420) send_random_set(0);
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_results != 0);
    repeat (2 * CAPACITY + 20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== interval_merge.f =====
hdl/imr_pkg.sv
hdl/imr_if.sv
hdl/imr_cell.sv
hdl/imr_sweep.sv
hdl/interval_merge.sv
tb/sv/imr_merge_checker.sv
tb/sv/tb_interval_merge.sv
